// ===== hw/rtl/pnei_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pnei_pkg: shared types and constants for the nearest-edge vertex table
// Transaction structs, state enums, arithmetic widths and reset vertices.
// ----------------------------------------------------------------------------
package pnei_pkg;

  // Coordinate format: signed Q3.12
  localparam int COORD_BITS       = 16;
  localparam int MAX_VERTICES_DEF = 64;

  // Datapath widths of the distance engine
  localparam int CW    = COORD_BITS;      // coordinate
  localparam int DW    = CW + 1;          // coordinate difference
  localparam int PW    = 2 * DW;          // signed difference product
  localparam int SW    = PW + 1;          // dot / cross sums
  localparam int DENW  = 2 * CW + 1;      // squared length
  localparam int MAGW  = 2 * CW + 2;      // cross product magnitude
  localparam int NUMW  = 2 * MAGW;        // distance numerator
  localparam int PRODW = NUMW + MAGW;     // cross-multiplied compare term

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_ADD    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_READ   = 3'd3,
    OP_WRITE  = 3'd4,
    OP_APPEND = 3'd5
  } op_t;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } vtx_t;

  typedef struct packed {
    logic [2:0]           opcode;
    logic signed [15:0]   x_coord;
    logic signed [15:0]   y_coord;
    logic                 closed_flag;
    logic [5:0]           slot_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [15:0]   read_x;
    logic signed [15:0]   read_y;
    logic [6:0]           placed_at;
    logic [6:0]           vertex_count;
    logic                 changed;
  } result_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_RD_WAIT,
    S_ADD_LAST,
    S_ADD_FIRST,
    S_SEG_RUN,
    S_SEG_RD,
    S_SEG_END,
    S_INS,
    S_SHIFT,
    S_RM,
    S_RM_WR,
    S_DONE
  } ctl_state_t;

  typedef enum logic [3:0] {
    E_IDLE,
    E_PROD,
    E_SUM,
    E_CASE,
    E_SQ,
    E_LOAD,
    E_MUL_L,
    E_MUL_R,
    E_FIN
  } eng_state_t;

  // Vertices loaded after reset: (0.2,0.2), (0.7,0.4), (0.4,0.7)
  function automatic vtx_t default_vtx(input logic [1:0] i);
    vtx_t v;
    case (i)
      2'd0:    v = '{x: 16'sd819,  y: 16'sd819};
      2'd1:    v = '{x: 16'sd2867, y: 16'sd1638};
      default: v = '{x: 16'sd1638, y: 16'sd2867};
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pnei_vtx_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pnei_vtx_mem: vertex store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pnei_vtx_mem
  import pnei_pkg::*;
#(
  parameter int DEPTH = MAX_VERTICES_DEF,
  parameter int AW    = $clog2(MAX_VERTICES_DEF)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire vtx_t          wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output vtx_t               rdata
);

  vtx_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/pnei_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pnei_mul: iterative unsigned multiplier
// Consumes four multiplier bits per cycle with a shift-and-add accumulator.
// ----------------------------------------------------------------------------
module pnei_mul
  import pnei_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUMW-1:0]  a,
  input  wire logic [MAGW-1:0]  b,
  output logic                  done,
  output logic [PRODW-1:0]      p
);

  localparam int DIG   = 4;
  localparam int STEPS = (MAGW + DIG - 1) / DIG;
  localparam int CNTW  = $clog2(STEPS + 1);

  logic [PRODW-1:0] areg;
  logic [MAGW-1:0]  breg;
  logic [PRODW-1:0] acc;
  logic [CNTW-1:0]  cnt;
  logic             run;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == CNTW'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= CNTW'(STEPS);
      end else if (run) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  // shift-and-add datapath
  always_ff @(posedge clk) begin
    if (start) begin
      areg <= PRODW'(a);
      breg <= b;
      acc  <= '0;
    end else if (run) begin
      acc  <= acc + areg * PRODW'(breg[DIG-1:0]);
      areg <= areg << DIG;
      breg <= breg >> DIG;
    end
  end

  assign p = acc;

endmodule
`default_nettype wire

// ===== hw/rtl/pnei_seg_dist.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pnei_seg_dist: point-to-segment distance engine
// Computes the squared distance as an exact fraction and compares it with
// the best one seen so far; also reports whether the end is farther than the
// start.
// ----------------------------------------------------------------------------
module pnei_seg_dist
  import pnei_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 init,
  input  wire vtx_t                 a,
  input  wire vtx_t                 b,
  input  wire logic signed [CW-1:0] px,
  input  wire logic signed [CW-1:0] py,
  output logic                      done,
  output logic                      better,
  output logic                      bfar
);

  localparam int NSTEP = 10;

  eng_state_t state, state_next;

  logic [3:0]              step;
  logic signed [DW-1:0]    dx, dy, wx, wy, ex, ey;
  logic signed [PW-1:0]    pp [NSTEP];
  logic [DENW-1:0]         len2, da, db;
  logic signed [SW-1:0]    t, c;
  logic [NUMW-1:0]         num, best_num;
  logic [DENW-1:0]         den, best_den;
  logic [PRODW-1:0]        lprod;
  logic                    better_q, bfar_q, init_q;

  logic signed [DW-1:0]    op_a, op_b;
  logic signed [PW-1:0]    prod;
  logic [MAGW-1:0]         cmag;
  logic                    at_start, at_end, perp;

  logic                    mul_start, mul_done;
  logic [NUMW-1:0]         mul_a;
  logic [MAGW-1:0]         mul_b;
  logic [PRODW-1:0]        mul_p;

  pnei_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // product operand select, one product per cycle
  always_comb begin
    case (step)
      4'd0:    begin op_a = dx; op_b = dx; end
      4'd1:    begin op_a = dy; op_b = dy; end
      4'd2:    begin op_a = wx; op_b = dx; end
      4'd3:    begin op_a = wy; op_b = dy; end
      4'd4:    begin op_a = wx; op_b = dy; end
      4'd5:    begin op_a = wy; op_b = dx; end
      4'd6:    begin op_a = wx; op_b = wx; end
      4'd7:    begin op_a = wy; op_b = wy; end
      4'd8:    begin op_a = ex; op_b = ex; end
      default: begin op_a = ey; op_b = ey; end
    endcase
    prod = PW'(op_a) * PW'(op_b);
  end

  // projection case
  always_comb begin
    cmag     = c[SW-1] ? MAGW'(-c) : MAGW'(c);
    at_start = (len2 == '0) || t[SW-1] || (t == '0);
    at_end   = $unsigned(t) >= SW'(len2);
    perp     = !at_start && !at_end;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      E_IDLE:  if (start) state_next = E_PROD;
      E_PROD:  if (step == 4'(NSTEP - 1)) state_next = E_SUM;
      E_SUM:   state_next = E_CASE;
      E_CASE:  state_next = perp ? E_SQ : E_LOAD;
      E_SQ:    if (mul_done) state_next = E_LOAD;
      E_LOAD:  state_next = init_q ? E_FIN : E_MUL_L;
      E_MUL_L: if (mul_done) state_next = E_MUL_R;
      E_MUL_R: if (mul_done) state_next = E_FIN;
      E_FIN:   state_next = E_IDLE;
      default: state_next = E_IDLE;
    endcase
  end

  // multiplier requests
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      E_CASE: begin
        mul_start = perp;
        mul_a     = NUMW'(cmag);
        mul_b     = cmag;
      end
      E_LOAD: begin
        mul_start = !init_q;
        mul_a     = num;
        mul_b     = MAGW'(best_den);
      end
      E_MUL_L: begin
        mul_start = mul_done;
        mul_a     = best_num;
        mul_b     = MAGW'(den);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  assign done   = (state == E_FIN);
  assign better = better_q;
  assign bfar   = bfar_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      E_IDLE: begin
        if (start) begin
          dx       <= DW'(b.x) - DW'(a.x);
          dy       <= DW'(b.y) - DW'(a.y);
          wx       <= DW'(px) - DW'(a.x);
          wy       <= DW'(py) - DW'(a.y);
          ex       <= DW'(px) - DW'(b.x);
          ey       <= DW'(py) - DW'(b.y);
          init_q   <= init;
          step     <= '0;
          better_q <= 1'b0;
        end
      end
      E_PROD: begin
        pp[step] <= prod;
        step     <= step + 4'd1;
      end
      E_SUM: begin
        len2 <= DENW'(pp[0]) + DENW'(pp[1]);
        t    <= SW'(pp[2]) + SW'(pp[3]);
        c    <= SW'(pp[4]) - SW'(pp[5]);
        da   <= DENW'(pp[6]) + DENW'(pp[7]);
        db   <= DENW'(pp[8]) + DENW'(pp[9]);
      end
      E_CASE: begin
        bfar_q <= db > da;
        if (perp) begin
          den <= len2;
        end else begin
          num <= at_start ? NUMW'(da) : NUMW'(db);
          den <= DENW'(1);
        end
      end
      E_SQ: begin
        if (mul_done) num <= mul_p[NUMW-1:0];
      end
      E_LOAD: begin
        if (init_q) better_q <= 1'b1;
      end
      E_MUL_L: begin
        if (mul_done) lprod <= mul_p;
      end
      E_MUL_R: begin
        if (mul_done) better_q <= lprod < mul_p;
      end
      E_FIN: begin
        if (better_q) begin
          best_num <= num;
          best_den <= den;
        end
      end
      default: begin
      end
    endcase
  end

  // engine checks
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("engine done held");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == E_IDLE) else $error("engine started while busy");
  a_init_wins: assert property (@(posedge clk) disable iff (rst)
    (done && init_q) |-> better) else $error("first segment not taken");

endmodule
`default_nettype wire

// ===== hw/rtl/polygon_nearest_edge_insert.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_nearest_edge_insert: ordered polygon vertex table
// Clear, nearest-edge add, remove, read, write and raw append on a table of
// Q3.12 vertices held in a single-port-read synchronous memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on result for one cycle with done high and cannot be held off.
// Clear, write and rejected commands go straight to the result, and read first
// waits for the read data. Raw append, and add with fewer than 3 vertices,
// write the point at the end. Add with n >= 3 vertices walks all n segments
// through the distance engine (ten products on one 17x17 multiplier, then up
// to three products of nine four-bit steps each on a shift-and-add
// multiplier; the closing segment needs no compare), then shifts the tail up
// one vertex at a time to open the insertion slot.
// Remove shifts each vertex after the removed one down by one. After reset
// the block loads the three default vertices with busy high.
// ----------------------------------------------------------------------------
module polygon_nearest_edge_insert
  import pnei_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output logic      done,
  output result_t   result
);

  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int CMPW = (CNTW > 6) ? CNTW : 6;
  localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_VERTICES);

  ctl_state_t state, state_next;

  cmd_t            req;
  result_t         res;
  logic [CNTW-1:0] total, k, pos, bidx;
  vtx_t            last, prev;
  logic            first_seg, bfar_q;

  // memory and engine hookup
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  vtx_t            mem_wdata, rdata;
  logic            eng_start, eng_done, eng_better, eng_bfar;
  vtx_t            eng_a;

  // command decode
  logic            accept, full, direct, idx_ok;
  logic [CMPW-1:0] idx_ext;
  logic [CNTW-1:0] idx_c;
  vtx_t            cmd_pt, req_pt;

  pnei_vtx_mem #(.DEPTH(MAX_VERTICES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  pnei_seg_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .start  (eng_start),
    .init   (state == S_ADD_FIRST),
    .a      (eng_a),
    .b      (rdata),
    .px     (req.x_coord),
    .py     (req.y_coord),
    .done   (eng_done),
    .better (eng_better),
    .bfar   (eng_bfar)
  );

  // decode helpers
  always_comb begin
    accept  = start && (state == S_IDLE);
    full    = total >= MAXC;
    direct  = (op_t'(cmd.opcode) == OP_APPEND) || (total < CNTW'(3));
    idx_ext = CMPW'(cmd.slot_index);
    idx_ok  = idx_ext < CMPW'(total);
    idx_c   = CNTW'(idx_ext);
    cmd_pt  = '{x: cmd.x_coord, y: cmd.y_coord};
    req_pt  = '{x: req.x_coord, y: req.y_coord};
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: if (k == CNTW'(2)) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (op_t'(cmd.opcode))
            OP_ADD, OP_APPEND: begin
              if (full)        state_next = S_DONE;
              else if (direct) state_next = S_INS;
              else             state_next = S_ADD_LAST;
            end
            OP_REMOVE:
              state_next = (total < CNTW'(4) || !idx_ok) ? S_DONE : S_RM;
            OP_READ: state_next = idx_ok ? S_RD_WAIT : S_DONE;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_ADD_LAST:  state_next = S_ADD_FIRST;
      S_ADD_FIRST: state_next = S_SEG_RUN;
      S_SEG_RUN: begin
        if (eng_done) state_next = (k < total) ? S_SEG_RD : S_SEG_END;
      end
      S_SEG_RD:  state_next = S_SEG_RUN;
      S_SEG_END: state_next = S_INS;
      S_INS:     state_next = (k > pos) ? S_SHIFT : S_DONE;
      S_SHIFT:   state_next = S_INS;
      S_RM:      state_next = (CNTW'(k + CNTW'(1)) < total) ? S_RM_WR : S_DONE;
      S_RM_WR:   state_next = S_RM;
      S_RD_WAIT: state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // memory and engine controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rdata;
    mem_re    = 1'b0;
    mem_raddr = '0;
    eng_start = 1'b0;
    eng_a     = prev;
    unique case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = k[AW-1:0];
        mem_wdata = default_vtx(k[1:0]);
      end
      S_IDLE: begin
        if (accept && idx_ok &&
            (op_t'(cmd.opcode) == OP_READ || op_t'(cmd.opcode) == OP_WRITE)) begin
          mem_re    = op_t'(cmd.opcode) == OP_READ;
          mem_raddr = idx_c[AW-1:0];
          mem_we    = op_t'(cmd.opcode) == OP_WRITE;
          mem_waddr = idx_c[AW-1:0];
          mem_wdata = cmd_pt;
        end
        if (accept && op_t'(cmd.opcode) == OP_ADD && !full && !direct) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(total - CNTW'(1));
        end
      end
      S_ADD_LAST: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      S_ADD_FIRST: begin
        eng_start = 1'b1;
        eng_a     = last;
      end
      S_SEG_RUN: begin
        mem_re    = eng_done && (k < total);
        mem_raddr = k[AW-1:0];
      end
      S_SEG_RD: begin
        eng_start = 1'b1;
      end
      S_INS: begin
        if (k > pos) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(k - CNTW'(1));
        end else begin
          mem_we    = 1'b1;
          mem_waddr = pos[AW-1:0];
          mem_wdata = req_pt;
        end
      end
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = k[AW-1:0];
      end
      S_RM: begin
        mem_re    = CNTW'(k + CNTW'(1)) < total;
        mem_raddr = AW'(k + CNTW'(1));
      end
      S_RM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = k[AW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= CNTW'(3);
      k     <= '0;
    end else begin
      unique case (state)
        S_INIT: k <= k + CNTW'(1);
        S_IDLE: begin
          if (accept) begin
            case (op_t'(cmd.opcode))
              OP_CLEAR:          total <= '0;
              OP_ADD, OP_APPEND: k <= total;
              OP_REMOVE:         k <= idx_c;
              default:           k <= k;
            endcase
          end
        end
        S_ADD_FIRST: k <= CNTW'(1);
        S_SEG_RD:    k <= k + CNTW'(1);
        S_SEG_END:   k <= total;
        S_INS:       if (!(k > pos)) total <= total + CNTW'(1);
        S_SHIFT:     k <= k - CNTW'(1);
        S_RM: begin
          if (!(CNTW'(k + CNTW'(1)) < total)) total <= total - CNTW'(1);
        end
        S_RM_WR:     k <= k + CNTW'(1);
        default:     k <= k;
      endcase
    end
  end

  // command, scan and result registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          req <= cmd;
          res <= '0;
          pos <= total;
          case (op_t'(cmd.opcode))
            OP_CLEAR: res.changed <= 1'b1;
            OP_ADD, OP_APPEND: begin
              if (full) res.status <= ST_FULL;
            end
            OP_REMOVE: begin
              if (total < CNTW'(4) || !idx_ok) res.status <= ST_REJECT;
            end
            OP_READ: begin
              if (!idx_ok) res.status <= ST_REJECT;
            end
            OP_WRITE: begin
              if (!idx_ok) res.status <= ST_REJECT;
              else         res.changed <= 1'b1;
            end
            default: res.status <= ST_REJECT;
          endcase
        end
      end
      S_ADD_LAST: last <= rdata;
      S_ADD_FIRST: begin
        prev      <= rdata;
        first_seg <= 1'b1;
        bidx      <= '0;
        pos       <= '0;
      end
      S_SEG_RUN: begin
        if (eng_done) begin
          first_seg <= 1'b0;
          if (first_seg) bfar_q <= eng_bfar;
          if (eng_better) pos <= bidx;
        end
      end
      S_SEG_RD: begin
        prev <= rdata;
        bidx <= k;
      end
      S_SEG_END: begin
        // open polygon: a far first vertex sends the point to the end
        if (!req.closed_flag && pos == '0 && bfar_q) pos <= total;
      end
      S_INS: begin
        if (!(k > pos)) begin
          res.placed_at <= 7'(pos);
          res.changed   <= 1'b1;
        end
      end
      S_RM: begin
        if (!(CNTW'(k + CNTW'(1)) < total)) res.changed <= 1'b1;
      end
      S_RD_WAIT: begin
        res.read_x <= rdata.x;
        res.read_y <= rdata.y;
      end
      default: begin
      end
    endcase
  end

  // result port
  always_comb begin
    busy                = (state != S_IDLE);
    done                = (state == S_DONE);
    result              = res;
    result.vertex_count = 7'(total);
  end

  // checks
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("transaction accepted without going busy");
  a_total_max: assert property (@(posedge clk) disable iff (rst)
    total <= MAXC) else $error("vertex count beyond table size");
  a_full_nochange: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> !result.changed)
    else $error("full table reported a change");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_INIT && state != S_DONE) |->
    (total == $past(total) || total == $past(total) + CNTW'(1) ||
     total == $past(total) - CNTW'(1)))
    else $error("vertex count jumped");

endmodule
`default_nettype wire
